>>> hw/rtl/bbtemp_pkg.sv
// ----------------------------------------------------------------------------
// bbtemp_pkg
// Constants, knot tables, types and helper functions of the blackbody
// color temperature to RGB gain pipeline.
// ----------------------------------------------------------------------------
package bbtemp_pkg;

  localparam int KNOT_COUNT    = 22;
  localparam int OUT_FRAC_BITS = 13;

  localparam int TABLE_LEN = 22;
  localparam int T_MIN     = 1000;
  localparam int T_MAX     = 10000;
  localparam int T_SPAN    = 9000;
  localparam int FRAC_BITS = 16;
  localparam int SEG_MAX   = KNOT_COUNT - 4;

  localparam int TEMP_W = 16;
  localparam int GAIN_W = 16;
  localparam int SPAN_W = $clog2(T_SPAN);
  localparam int N_W    = $clog2(T_SPAN * SEG_MAX + 1);
  localparam int IDX_W  = $clog2(KNOT_COUNT);
  localparam int X_W    = SPAN_W + FRAC_BITS;

  // floor(2^31 / 9000); estimate is low by at most one
  localparam longint RECIP       = 238609;
  localparam int     RECIP_SHIFT = 31;

  localparam int KNOT_W = 22;
  localparam int COEF_W = 27;
  localparam int M_W    = COEF_W + FRAC_BITS + 1;
  localparam int S_W    = 42;

  localparam int LUMA_R = 2126;
  localparam int LUMA_G = 7152;
  localparam int LUMA_B = 722;

  localparam longint GAIN_SCALE = 64'd10000 * (64'd1 << OUT_FRAC_BITS);
  localparam int     SCALE_W    = $clog2(GAIN_SCALE + 1);
  localparam int     NUM_W      = COEF_W - 1 + SCALE_W;
  localparam int     R_W        = ((NUM_W > S_W + 15) ? NUM_W : S_W + 15) + 1;
  localparam int     DIV_STEPS  = GAIN_W;
  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int CH_COUNT = 3;

  localparam logic [20:0] KNOT_RED [TABLE_LEN] = '{
    21'd1048576, 21'd1048576, 21'd1048576, 21'd1048576, 21'd1048576,
    21'd1048576, 21'd1048576, 21'd1048576, 21'd1048576, 21'd1048576,
    21'd1048576, 21'd1048576, 21'd1048576, 21'd951003,  21'd868480,
    21'd802990,  21'd749999,  21'd706408,  21'd670032,  21'd639297,
    21'd639297,  21'd639297
  };
  localparam logic [20:0] KNOT_GREEN [TABLE_LEN] = '{
    21'd28825,  21'd28825,  21'd156934, 21'd269111, 21'd390105,
    21'd499882, 21'd598083, 21'd685223, 21'd762187, 21'd829993,
    21'd889677, 21'd942230, 21'd988567, 21'd933711, 21'd882731,
    21'd840849, 21'd805913, 21'd776390, 21'd751157, 21'd729377,
    21'd729377, 21'd729377
  };
  localparam logic [20:0] KNOT_BLUE [TABLE_LEN] = '{
    21'd0,       21'd0,       21'd0,       21'd8488,    21'd70726,
    21'd161062,  21'd271787,  21'd395476,  21'd525972,  21'd658558,
    21'd789817,  21'd917404,  21'd1039812, 21'd1048576, 21'd1048576,
    21'd1048576, 21'd1048576, 21'd1048576, 21'd1048576, 21'd1048576,
    21'd1048576, 21'd1048576
  };

  typedef logic signed [KNOT_W-1:0] knot_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [M_W-1:0]    prod_t;

  typedef struct packed {
    coef_t a;
    coef_t b;
    coef_t c;
    coef_t d;
  } cubic_t;

  function automatic knot_t knot_value(input logic [IDX_W:0] idx, input int ch);
    int          sel;
    logic [20:0] raw;
    sel = (int'(idx) >= TABLE_LEN) ? TABLE_LEN - 1 : int'(idx);
    unique case (ch)
      CH_RED:   raw = KNOT_RED[sel];
      CH_GREEN: raw = KNOT_GREEN[sel];
      default:  raw = KNOT_BLUE[sel];
    endcase
    return knot_t'({1'b0, raw});
  endfunction

  function automatic cubic_t make_cubic(input knot_t k0, input knot_t k1,
                                        input knot_t k2, input knot_t k3);
    coef_t  e0, e1, e2, e3, d12;
    cubic_t r;
    e0  = COEF_W'(k0);
    e1  = COEF_W'(k1);
    e2  = COEF_W'(k2);
    e3  = COEF_W'(k3);
    d12 = e1 - e2;
    r.a = e3 - e0 + (d12 <<< 1) + d12;
    r.b = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
    r.c = e2 - e0;
    r.d = e1 <<< 1;
    return r;
  endfunction

  // floor((m + 2^15) / 2^16) + k
  function automatic coef_t round_add(input prod_t m, input coef_t k);
    prod_t y;
    y = m + M_W'(1 << (FRAC_BITS - 1));
    return COEF_W'(y >>> FRAC_BITS) + k;
  endfunction

endpackage

>>> hw/rtl/bbtemp_in_if.sv
// ----------------------------------------------------------------------------
// bbtemp_in_if
// Temperature channel: valid/ready handshake with one kelvin value.
// ----------------------------------------------------------------------------
interface bbtemp_in_if;
  logic                            valid;
  logic                            ready;
  logic [bbtemp_pkg::TEMP_W-1:0]   temperature_kelvin;

  modport source (output valid, output temperature_kelvin, input ready);
  modport sink   (input valid, input temperature_kelvin, output ready);
endinterface

>>> hw/rtl/bbtemp_out_if.sv
// ----------------------------------------------------------------------------
// bbtemp_out_if
// Gain channel: valid/ready handshake with one RGB gain triple.
// ----------------------------------------------------------------------------
interface bbtemp_out_if;
  logic                          valid;
  logic                          ready;
  logic [bbtemp_pkg::GAIN_W-1:0] red_gain;
  logic [bbtemp_pkg::GAIN_W-1:0] green_gain;
  logic [bbtemp_pkg::GAIN_W-1:0] blue_gain;

  modport source (output valid, output red_gain, output green_gain, output blue_gain,
                  input ready);
  modport sink   (input valid, input red_gain, input green_gain, input blue_gain,
                  output ready);
endinterface

>>> hw/rtl/blackbody_temperature_to_rgb.sv
// ----------------------------------------------------------------------------
// blackbody_temperature_to_rgb
// Blackbody color temperature to luma-normalized RGB gains, Q3.13.
// ----------------------------------------------------------------------------
// Accepts one temperature per cycle unless the output stalls, and returns one
// gain triple per transfer. The pipeline is made up of the segment and fraction
// split (five stages), the three Horner multiply/round steps (six stages), the
// luma and scaling stages, and a 16-stage restoring divider that produces one
// quotient bit per stage for each channel. A stall at the output holds the whole
// pipeline in place.
module blackbody_temperature_to_rgb (
  input  logic            clk,
  input  logic            rst,
  bbtemp_in_if.sink       temperature,
  bbtemp_out_if.source    gains
);
  import bbtemp_pkg::*;

  localparam int DIV0 = 12;
  localparam int LAST = DIV0 + DIV_STEPS + 1;

  logic [LAST:0] vld;
  logic          adv;

  assign adv               = !vld[LAST] || gains.ready;
  assign temperature.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], temperature.valid};
    end
  end

  // clamp and scale
  logic [TEMP_W-1:0] t_clamp;
  logic [N_W-1:0]    s0_n;

  always_comb begin
    if (temperature.temperature_kelvin < TEMP_W'(T_MIN)) begin
      t_clamp = TEMP_W'(T_MIN);
    end else if (temperature.temperature_kelvin > TEMP_W'(T_MAX)) begin
      t_clamp = TEMP_W'(T_MAX);
    end else begin
      t_clamp = temperature.temperature_kelvin;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_n <= N_W'(32'(t_clamp - TEMP_W'(T_MIN)) * SEG_MAX);
    end
  end

  // segment estimate
  logic [N_W-1:0]   s1_n;
  logic [IDX_W-1:0] s1_q0;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_n  <= s0_n;
      s1_q0 <= IDX_W'((64'(s0_n) * RECIP) >> RECIP_SHIFT);
    end
  end

  // segment correction
  logic [N_W-1:0]    r0;
  logic [IDX_W-1:0]  s2_seg;
  logic [SPAN_W-1:0] s2_r;

  assign r0 = s1_n - N_W'(32'(s1_q0) * T_SPAN);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (r0 >= N_W'(T_SPAN)) begin
        s2_seg <= s1_q0 + 1'b1;
        s2_r   <= SPAN_W'(r0 - N_W'(T_SPAN));
      end else begin
        s2_seg <= s1_q0;
        s2_r   <= SPAN_W'(r0);
      end
    end
  end

  // fraction estimate
  logic [IDX_W-1:0]     s3_seg;
  logic [SPAN_W-1:0]    s3_r;
  logic [FRAC_BITS-1:0] s3_u0;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_seg <= s2_seg;
      s3_r   <= s2_r;
      s3_u0  <= FRAC_BITS'((64'({s2_r, {FRAC_BITS{1'b0}}}) * RECIP) >> RECIP_SHIFT);
    end
  end

  // fraction correction and cubic coefficients
  logic [X_W-1:0]       rem_u;
  logic [FRAC_BITS-1:0] s4_u;
  cubic_t               s4_cub [CH_COUNT];

  assign rem_u = {s3_r, {FRAC_BITS{1'b0}}} - X_W'(32'(s3_u0) * T_SPAN);

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_u <= (rem_u >= X_W'(T_SPAN)) ? s3_u0 + 1'b1 : s3_u0;
      for (int ch = 0; ch < CH_COUNT; ch++) begin
        s4_cub[ch] <= make_cubic(knot_value({1'b0, s3_seg}, ch),
                                 knot_value({1'b0, s3_seg} + 1'b1, ch),
                                 knot_value({1'b0, s3_seg} + 2'd2, ch),
                                 knot_value({1'b0, s3_seg} + 2'd3, ch));
      end
    end
  end

  // Horner evaluation
  logic [FRAC_BITS-1:0] s5_u, s6_u, s7_u, s8_u, s9_u;
  cubic_t               s5_cub [CH_COUNT];
  cubic_t               s6_cub [CH_COUNT];
  cubic_t               s7_cub [CH_COUNT];
  cubic_t               s8_cub [CH_COUNT];
  cubic_t               s9_cub [CH_COUNT];
  prod_t                s5_m [CH_COUNT];
  coef_t                s6_p [CH_COUNT];
  prod_t                s7_m [CH_COUNT];
  coef_t                s8_p [CH_COUNT];
  prod_t                s9_m [CH_COUNT];
  coef_t                s10_chan [CH_COUNT];

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_u <= s4_u;
      s6_u <= s5_u;
      s7_u <= s6_u;
      s8_u <= s7_u;
      s9_u <= s8_u;
      for (int ch = 0; ch < CH_COUNT; ch++) begin
        s5_cub[ch]   <= s4_cub[ch];
        s6_cub[ch]   <= s5_cub[ch];
        s7_cub[ch]   <= s6_cub[ch];
        s8_cub[ch]   <= s7_cub[ch];
        s9_cub[ch]   <= s8_cub[ch];
        s5_m[ch]     <= s4_cub[ch].a * $signed({1'b0, s4_u});
        s6_p[ch]     <= round_add(s5_m[ch], s5_cub[ch].b);
        s7_m[ch]     <= s6_p[ch] * $signed({1'b0, s6_u});
        s8_p[ch]     <= round_add(s7_m[ch], s7_cub[ch].c);
        s9_m[ch]     <= s8_p[ch] * $signed({1'b0, s8_u});
        s10_chan[ch] <= round_add(s9_m[ch], s9_cub[ch].d);
      end
    end
  end

  // luma sum and scaled numerators
  logic signed [S_W-1:0] s11_s;
  logic [NUM_W-1:0]      s11_num  [CH_COUNT];
  logic                  s11_zero [CH_COUNT];

  always_ff @(posedge clk) begin
    if (adv) begin
      s11_s <= S_W'(s10_chan[CH_RED])   * S_W'(LUMA_R)
             + S_W'(s10_chan[CH_GREEN]) * S_W'(LUMA_G)
             + S_W'(s10_chan[CH_BLUE])  * S_W'(LUMA_B);
      for (int ch = 0; ch < CH_COUNT; ch++) begin
        s11_zero[ch] <= !(s10_chan[ch] > 0);
        s11_num[ch]  <= (s10_chan[ch] > 0)
                      ? NUM_W'(s10_chan[ch][COEF_W-2:0]) * NUM_W'(GAIN_SCALE)
                      : '0;
      end
    end
  end

  // divider: stage 0 forms rounded dividend, later stages take one bit each
  logic [R_W-1:0]    dv_den  [DIV_STEPS+1];
  logic [R_W-1:0]    dv_rem  [DIV_STEPS+1][CH_COUNT];
  logic [GAIN_W-1:0] dv_q    [DIV_STEPS+1][CH_COUNT];
  logic              dv_sat  [DIV_STEPS+1][CH_COUNT];
  logic              dv_zero [DIV_STEPS+1][CH_COUNT];

  logic [R_W-1:0] den0;
  logic           s_pos;

  assign s_pos = s11_s > 0;
  assign den0  = R_W'(s11_s[S_W-2:0]);

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_den[0] <= den0;
      for (int ch = 0; ch < CH_COUNT; ch++) begin
        dv_rem[0][ch]  <= R_W'(s11_num[ch]) + (den0 >> 1);
        dv_q[0][ch]    <= '0;
        dv_zero[0][ch] <= s11_zero[ch] || !s_pos;
        dv_sat[0][ch]  <= (R_W'(s11_num[ch]) + (den0 >> 1)) >= (den0 << DIV_STEPS);
      end
    end
  end

  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    logic [R_W-1:0] shf;
    assign shf = dv_den[j-1] << (DIV_STEPS - j);

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_den[j] <= dv_den[j-1];
        for (int ch = 0; ch < CH_COUNT; ch++) begin
          dv_sat[j][ch]  <= dv_sat[j-1][ch];
          dv_zero[j][ch] <= dv_zero[j-1][ch];
          if (dv_rem[j-1][ch] >= shf) begin
            dv_rem[j][ch] <= dv_rem[j-1][ch] - shf;
            dv_q[j][ch]   <= {dv_q[j-1][ch][GAIN_W-2:0], 1'b1};
          end else begin
            dv_rem[j][ch] <= dv_rem[j-1][ch];
            dv_q[j][ch]   <= {dv_q[j-1][ch][GAIN_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  // output register
  logic [GAIN_W-1:0] out_gain [CH_COUNT];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int ch = 0; ch < CH_COUNT; ch++) begin
        priority if (dv_zero[DIV_STEPS][ch]) begin
          out_gain[ch] <= '0;
        end else if (dv_sat[DIV_STEPS][ch]) begin
          out_gain[ch] <= GAIN_MAX;
        end else begin
          out_gain[ch] <= dv_q[DIV_STEPS][ch];
        end
      end
    end
  end

  assign gains.valid      = vld[LAST];
  assign gains.red_gain   = out_gain[CH_RED];
  assign gains.green_gain = out_gain[CH_GREEN];
  assign gains.blue_gain  = out_gain[CH_BLUE];

`ifndef SYNTH
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> vld == $past(vld))
    else $error("pipeline valid bits moved during a stall");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> s2_r < SPAN_W'(T_SPAN))
    else $error("segment remainder out of range");

  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> s2_seg <= IDX_W'(SEG_MAX))
    else $error("segment index beyond last segment");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    vld[LAST-1] && !dv_sat[DIV_STEPS][CH_GREEN] && !dv_zero[DIV_STEPS][CH_GREEN]
      |-> dv_rem[DIV_STEPS][CH_GREEN] < dv_den[DIV_STEPS])
    else $error("divider remainder not below divisor");
`endif

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of blackbody_temperature_to_rgb: directed temperatures from a
// table, then random ones, with random gaps on both handshakes. Gain triples
// are compared with a bit-exact spline and luma predictor or a hand-typed value.
// ----------------------------------------------------------------------------
module tb_top;
  import bbtemp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  bbtemp_in_if  temp_ch ();
  bbtemp_out_if gain_ch ();

  blackbody_temperature_to_rgb uut (
    .clk(clk), .rst(rst), .temperature(temp_ch.sink), .gains(gain_ch.source)
  );

  typedef struct {
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
  } gains_t;

  typedef struct {
    logic [15:0] kelvin;
    bit          typed;
    gains_t      want;
  } row_t;

  localparam longint KNOTS [22][3] = '{
    '{1048576, 28825, 0}, '{1048576, 28825, 0}, '{1048576, 156934, 0},
    '{1048576, 269111, 8488}, '{1048576, 390105, 70726},
    '{1048576, 499882, 161062}, '{1048576, 598083, 271787},
    '{1048576, 685223, 395476}, '{1048576, 762187, 525972},
    '{1048576, 829993, 658558}, '{1048576, 889677, 789817},
    '{1048576, 942230, 917404}, '{1048576, 988567, 1039812},
    '{951003, 933711, 1048576}, '{868480, 882731, 1048576},
    '{802990, 840849, 1048576}, '{749999, 805913, 1048576},
    '{706408, 776390, 1048576}, '{670032, 751157, 1048576},
    '{639297, 729377, 1048576}, '{639297, 729377, 1048576},
    '{639297, 729377, 1048576}
  };

  gains_t pending_gains[$];
  int     errors = 0;
  int     in_count = 0;
  bit     stim_done = 1'b0;

  function automatic longint rnd16(longint x);
    longint y;
    y = x + 32768;
    if (y >= 0) return y >>> 16;
    return -(((-y) + 65535) >>> 16);
  endfunction

  function automatic logic [15:0] scale_gain(longint c, longint s);
    longint q;
    if (c <= 0 || s <= 0) return 16'd0;
    q = (c * 10000 * (longint'(1) << OUT_FRAC_BITS) + s / 2) / s;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic gains_t predict_gains(logic [15:0] kelvin);
    longint t, n, u, a, b, c, d, p, s;
    longint ch_val [3];
    int     seg, i0, i3;
    gains_t res;
    t = kelvin;
    if (t < 1000) t = 1000;
    if (t > 10000) t = 10000;
    n = (t - 1000) * (KNOT_COUNT - 4);
    seg = int'(n / 9000);
    u = ((n % 9000) << 16) / 9000;
    for (int ch = 0; ch < 3; ch++) begin
      i0 = seg;
      i3 = (seg + 3 > 21) ? 21 : seg + 3;
      a = -KNOTS[i0][ch] + 3 * KNOTS[seg + 1][ch] - 3 * KNOTS[seg + 2][ch] + KNOTS[i3][ch];
      b = 2 * KNOTS[i0][ch] - 5 * KNOTS[seg + 1][ch] + 4 * KNOTS[seg + 2][ch] - KNOTS[i3][ch];
      c = -KNOTS[i0][ch] + KNOTS[seg + 2][ch];
      d = 2 * KNOTS[seg + 1][ch];
      p = rnd16(a * u) + b;
      p = rnd16(p * u) + c;
      p = rnd16(p * u) + d;
      ch_val[ch] = p;
    end
    s = 2126 * ch_val[0] + 7152 * ch_val[1] + 722 * ch_val[2];
    res.r = scale_gain(ch_val[0], s);
    res.g = scale_gain(ch_val[1], s);
    res.b = scale_gain(ch_val[2], s);
    return res;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  function automatic row_t mk(logic [15:0] k);
    row_t r;
    r.kelvin = k;
    r.typed = 1'b0;
    r.want = '{16'd0, 16'd0, 16'd0};
    return r;
  endfunction

  task automatic send_temp(logic [15:0] k);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      temp_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    temp_ch.valid <= 1'b1;
    temp_ch.temperature_kelvin <= k;
    @(posedge clk);
    while (!temp_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  row_t directed [$];

  initial begin
    row_t   r;
    logic [15:0] k;
    temp_ch.valid = 1'b0;
    temp_ch.temperature_kelvin = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // At 1000 K and below red is 1.0 and blue zero; the luma ratio is exact here.
    directed.push_back(mk(16'd0));
    directed.push_back(mk(16'd999));
    directed.push_back(mk(16'd1000));
    directed.push_back(mk(16'd1001));
    directed.push_back(mk(16'd1500));
    directed.push_back(mk(16'd3000));
    directed.push_back(mk(16'd6500));
    directed.push_back(mk(16'd7000));
    directed.push_back(mk(16'd7250));
    directed.push_back(mk(16'd9499));
    directed.push_back(mk(16'd9999));
    directed.push_back(mk(16'd10000));
    directed.push_back(mk(16'd10001));
    directed.push_back(mk(16'hAAAA));
    directed.push_back(mk(16'h5555));
    directed.push_back(mk(16'hFFFF));
    // Red gain at 1000 K: 10000*8192*1048576*2 / S, S = 2126*2^21 + 7152*57650.
    r = mk(16'd1000);
    r.typed = 1'b1;
    r.want.r = 16'd35271;
    r.want.g = 16'd970;
    r.want.b = 16'd0;
    directed.push_back(r);
    foreach (directed[i]) begin
      pending_gains.push_back(directed[i].typed ? directed[i].want
                                                : predict_gains(directed[i].kelvin));
      send_temp(directed[i].kelvin);
      in_count++;
    end
    for (int i = 0; i < 1050; i++) begin
      case ($urandom_range(0, 9))
        0:       k = 16'($urandom_range(0, 65535));
        1:       k = 16'($urandom_range(0, 1100));
        2:       k = 16'($urandom_range(9900, 10100));
        default: k = 16'($urandom_range(1000, 10000));
      endcase
      pending_gains.push_back(predict_gains(k));
      send_temp(k);
      in_count++;
    end
    temp_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    gain_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      int gap;
      gap = gap_len();
      gain_ch.ready <= (gap == 0);
      if (gap > 0) repeat (gap) @(negedge clk);
      else @(negedge clk);
    end
  end

  always @(posedge clk) begin
    gains_t exp_g;
    if (!rst && gain_ch.valid && gain_ch.ready) begin
      if (pending_gains.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transfer: %h %h %h",
                                   gain_ch.red_gain, gain_ch.green_gain, gain_ch.blue_gain);
      end else begin
        exp_g = pending_gains.pop_front();
        if (gain_ch.red_gain !== exp_g.r || gain_ch.green_gain !== exp_g.g ||
            gain_ch.blue_gain !== exp_g.b) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                     exp_g.r, exp_g.g, exp_g.b,
                     gain_ch.red_gain, gain_ch.green_gain, gain_ch.blue_gain);
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    wait (pending_gains.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_gains.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

>>> filelist.f
hw/rtl/bbtemp_pkg.sv
hw/rtl/bbtemp_in_if.sv
hw/rtl/bbtemp_out_if.sv
hw/rtl/blackbody_temperature_to_rgb.sv
bench/tb_top.sv
